@@ hdl/dfcf_pkg.sv @@
package dfcf_pkg;

    localparam int IO_W   = 24;
    localparam int CFG_W  = 16;
    localparam int DLY_W  = 13;
    localparam int FB_W   = 16;
    localparam int DAMP_W = 16;
    localparam int GAIN_W = 32;

    typedef enum logic [1:0] {
        CFG_DELAY_LEN = 2'd0,
        CFG_FEEDBACK  = 2'd1,
        CFG_DAMP      = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain;
        logic [DAMP_W-1:0]        damp;
    } t_coef;

    typedef struct packed {
        logic       open;
        logic [1:0] inflight;
        logic       wr_en;
    } t_pipe_stat;

endpackage

@@ hdl/dfcf_delay_mem.sv @@
module dfcf_delay_mem #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 24,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/dfcf_damp_loop.sv @@
module dfcf_damp_loop #(
    parameter int SW = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_acc,
    input  logic signed [SW-1:0]              i_src,
    input  logic                              i_hit,
    input  logic [SW-1:0]                     i_rd_data,
    input  dfcf_pkg::t_coef                   i_coef,
    input  logic                              i_out_ready,
    output dfcf_pkg::t_pipe_stat              o_stat,
    output logic [SW-1:0]                     o_wr_data,
    output logic                              o_out_valid,
    output logic signed [dfcf_pkg::IO_W-1:0]  o_out_sample
);

    localparam int PW  = SW + dfcf_pkg::GAIN_W;
    localparam int ACW = SW + 34;
    localparam int LVW = ACW - 31;
    localparam int EW  = (SW > dfcf_pkg::IO_W) ? SW : dfcf_pkg::IO_W;
    localparam longint SMAXL = (longint'(1) <<< (SW - 1)) - 1;
    localparam longint SMINL = -SMAXL - 1;
    localparam logic signed [LVW-1:0] LV_MAX = LVW'(SMAXL);
    localparam logic signed [LVW-1:0] LV_MIN = LVW'(SMINL);
    localparam logic signed [SW:0]    WS_MAX = (SW + 1)'(SMAXL);
    localparam logic signed [SW:0]    WS_MIN = (SW + 1)'(SMINL);
    localparam logic signed [ACW-1:0] RND    = ACW'(longint'(1) <<< 30);

    logic                   r_s1_valid;
    logic signed [SW-1:0]   r_s1_src;
    logic                   r_s1_hit;
    logic                   r_s2_valid;
    logic signed [SW-1:0]   r_s2_src;
    logic signed [SW-1:0]   r_s2_smp;
    logic signed [PW-1:0]   r_s2_prod;
    logic signed [SW-1:0]   r_level;
    logic                   r_out_valid;
    logic signed [dfcf_pkg::IO_W-1:0] r_out_sample;

    logic                   s1_move;
    logic                   s2_move;
    logic signed [SW-1:0]   smp1;
    logic signed [PW-1:0]   prod1;
    logic signed [SW+16:0]  lvl_term;
    logic signed [ACW-1:0]  acc;
    logic signed [LVW-1:0]  lvl_raw;
    logic signed [SW-1:0]   lvl_new;
    logic signed [SW:0]     wsum;
    logic signed [SW-1:0]   wr_sat;
    logic signed [EW-1:0]   smp_ext;

    assign s2_move = r_s2_valid && (!r_out_valid || i_out_ready);
    assign s1_move = r_s1_valid && (!r_s2_valid || s2_move);

    assign o_stat.open     = !r_s1_valid || s1_move;
    assign o_stat.inflight = {1'b0, r_s1_valid} + {1'b0, r_s2_valid};
    assign o_stat.wr_en    = s2_move;

    // multiply the delayed sample by the loop gain
    always_comb begin
        smp1  = r_s1_hit ? $signed(i_rd_data) : '0;
        prod1 = smp1 * $signed(i_coef.gain);
    end

    // damped level update and write-back value
    always_comb begin
        lvl_term = r_level * $signed({1'b0, i_coef.damp});
        acc      = ACW'(r_s2_prod) + (ACW'(lvl_term) <<< 15) + RND;
        lvl_raw  = $signed(acc[ACW-1:31]);
        if (lvl_raw > LV_MAX) begin
            lvl_new = SW'(SMAXL);
        end else if (lvl_raw < LV_MIN) begin
            lvl_new = SW'(SMINL);
        end else begin
            lvl_new = lvl_raw[SW-1:0];
        end
        wsum = (SW + 1)'(lvl_new) + (SW + 1)'(r_s2_src);
        if (wsum > WS_MAX) begin
            wr_sat = SW'(SMAXL);
        end else if (wsum < WS_MIN) begin
            wr_sat = SW'(SMINL);
        end else begin
            wr_sat = wsum[SW-1:0];
        end
        smp_ext = EW'(r_s2_smp);
    end

    assign o_wr_data = wr_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_level     <= '0;
        end else begin
            if (i_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_s2_valid <= 1'b1;
            end else if (s2_move) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_move) begin
                r_out_valid <= 1'b1;
                r_level     <= lvl_new;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1_src <= i_src;
            r_s1_hit <= i_hit;
        end
        if (s1_move) begin
            r_s2_src  <= r_s1_src;
            r_s2_smp  <= smp1;
            r_s2_prod <= prod1;
        end
        if (s2_move) begin
            r_out_sample <= smp_ext[dfcf_pkg::IO_W-1:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;

endmodule

@@ hdl/damped_feedback_comb_filter.sv @@
// Lowpass feedback comb filter for reverb: each input transfer writes one sample into
// a circular delay memory and each output transfer returns the sample written
// delay_len transfers earlier. Results leave in input order. Throughput is one
// transfer per cycle while the effective delay is 3 or more and the output is not
// stalled; with a delay of 1 or 2 new inputs are held off until earlier ones are
// far enough along, because the read of an entry must follow its write-back, and
// read, multiply, level update and write-back are registered in turn. Entries not
// yet written since reset read as zero through a fill count, so the block is
// ready right after reset with no clearing pass. Write registers only while no
// transfer is in flight.
module damped_feedback_comb_filter #(
    parameter int MAX_DELAY   = 4096,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_idx,
    input  logic [dfcf_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [dfcf_pkg::IO_W-1:0]   i_in_sample,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [dfcf_pkg::IO_W-1:0]   o_out_sample
);

    localparam int AW = $clog2(MAX_DELAY);
    localparam int LW = $clog2(MAX_DELAY + 1);
    localparam int CW = (LW > dfcf_pkg::DLY_W) ? LW : dfcf_pkg::DLY_W;
    localparam int SW = SAMPLE_BITS;
    localparam int EW = (SW > dfcf_pkg::IO_W) ? SW : dfcf_pkg::IO_W;
    localparam longint SMAXL = (longint'(1) <<< (SW - 1)) - 1;
    localparam longint SMINL = -SMAXL - 1;
    localparam logic signed [EW-1:0] IN_MAX = EW'(SMAXL);
    localparam logic signed [EW-1:0] IN_MIN = EW'(SMINL);
    localparam logic [CW-1:0] MAXD_C   = CW'(MAX_DELAY);
    localparam logic [LW-1:0] MAXD_L   = LW'(MAX_DELAY);
    localparam logic [AW:0]   MAXD_F   = (AW + 1)'(MAX_DELAY);
    localparam logic [AW-1:0] LAST_PTR = AW'(MAX_DELAY - 1);

    logic [dfcf_pkg::DLY_W-1:0]         r_delay_len;
    logic signed [dfcf_pkg::FB_W-1:0]   r_feedback;
    logic [dfcf_pkg::DAMP_W-1:0]        r_damp;
    logic signed [dfcf_pkg::GAIN_W-1:0] r_gain;
    logic [AW-1:0]                      r_acc_ptr;
    logic [AW-1:0]                      r_wr_ptr;
    logic [AW:0]                        r_fill;

    logic [CW-1:0]          dl_ext;
    logic [LW-1:0]          dly;
    logic [LW-1:0]          ptr_ext;
    logic [LW-1:0]          rd_full;
    logic [AW-1:0]          rd_addr;
    logic                   rd_hit;
    logic signed [17:0]     inv_damp;
    logic signed [33:0]     gain_full;
    logic signed [EW-1:0]   in_ext;
    logic signed [SW-1:0]   src;
    logic                   acc;
    logic [SW-1:0]          rd_data;
    logic [SW-1:0]          wr_data;
    dfcf_pkg::t_coef        coef;
    dfcf_pkg::t_pipe_stat   stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_len <= dfcf_pkg::DLY_W'(1);
            r_feedback  <= '0;
            r_damp      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dfcf_pkg::CFG_DELAY_LEN: begin
                    r_delay_len <= i_cfg_data[dfcf_pkg::DLY_W-1:0];
                end
                dfcf_pkg::CFG_FEEDBACK: begin
                    r_feedback <= $signed(i_cfg_data[dfcf_pkg::FB_W-1:0]);
                end
                dfcf_pkg::CFG_DAMP: begin
                    r_damp <= i_cfg_data[dfcf_pkg::DAMP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        inv_damp  = 18'sd65536 - $signed({2'b00, r_damp});
        gain_full = r_feedback * inv_damp;
    end

    always_ff @(posedge i_clk) begin
        r_gain <= gain_full[dfcf_pkg::GAIN_W-1:0];
    end

    assign coef.gain = r_gain;
    assign coef.damp = r_damp;

    always_comb begin
        dl_ext = CW'(r_delay_len);
        if (dl_ext == '0) begin
            dly = LW'(1);
        end else if (dl_ext > MAXD_C) begin
            dly = MAXD_L;
        end else begin
            dly = dl_ext[LW-1:0];
        end
        ptr_ext = LW'(r_acc_ptr);
        if (ptr_ext >= dly) begin
            rd_full = ptr_ext - dly;
        end else begin
            rd_full = ptr_ext + MAXD_L - dly;
        end
        rd_addr = rd_full[AW-1:0];
        rd_hit  = {1'b0, rd_addr} < r_fill;
    end

    always_comb begin
        in_ext = EW'(i_in_sample);
        if (in_ext > IN_MAX) begin
            src = SW'(SMAXL);
        end else if (in_ext < IN_MIN) begin
            src = SW'(SMINL);
        end else begin
            src = in_ext[SW-1:0];
        end
    end

    // hold off while the first stage cannot advance or the entry to be read is still on its way to the memory
    assign o_in_ready = stat.open && (LW'(stat.inflight) < dly);
    assign acc        = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_ptr <= '0;
            r_wr_ptr  <= '0;
            r_fill    <= '0;
        end else begin
            if (acc) begin
                r_acc_ptr <= (r_acc_ptr == LAST_PTR) ? '0 : r_acc_ptr + AW'(1);
            end
            if (stat.wr_en) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
                if (r_fill != MAXD_F) begin
                    r_fill <= r_fill + (AW + 1)'(1);
                end
            end
        end
    end

    dfcf_delay_mem #(
        .DEPTH (MAX_DELAY),
        .WIDTH (SW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (stat.wr_en),
        .i_waddr (r_wr_ptr),
        .i_wdata (wr_data),
        .i_re    (acc),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    dfcf_damp_loop #(
        .SW (SW)
    ) u_loop (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (acc),
        .i_src        (src),
        .i_hit        (rd_hit),
        .i_rd_data    (rd_data),
        .i_coef       (coef),
        .i_out_ready  (i_out_ready),
        .o_stat       (stat),
        .o_wr_data    (wr_data),
        .o_out_valid  (o_out_valid),
        .o_out_sample (o_out_sample)
    );

endmodule
